[design/mm4_pkg.sv]
// Shared types and constants for the fixed-point matrix multiplier.
`timescale 1ns / 1ps

package mm4_pkg;

  // Fixed field widths of the beat payloads
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * VAL_W;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_FLUSH
  } mm4_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // store the accepted input beat
    logic issue;       // read one pair of operands
    logic first;       // issued pair starts a new dot product
    logic last;        // issued pair ends the dot product
    logic push;        // move the finished dot product to the output register
    logic final_elem;  // pushed element is the last of the matrix
  } mm4_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic dot_ready;   // accumulator holds a complete dot product
    logic slot_free;   // output register can take a new element this cycle
  } mm4_stat_t;

endpackage

[design/mm4_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/mm4_ctrl.sv]
// Controller: load / multiply-accumulate / flush sequencing and index counters.
`timescale 1ns / 1ps

module mm4_ctrl #(
  parameter int DIM = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_load_done,
  output logic                               in_ready,
  input  mm4_pkg::mm4_stat_t                 stat,
  output mm4_pkg::mm4_cmd_t                  cmd,
  output logic [$clog2(DIM*DIM)-1:0]         a_addr,
  output logic [$clog2(DIM*DIM)-1:0]         b_addr,
  output logic [mm4_pkg::IDX_W-1:0]          out_pos
);

  localparam int CELL_W = $clog2(DIM * DIM);
  localparam int ROW_W  = $clog2(DIM);
  localparam logic [ROW_W-1:0] LAST_RC = ROW_W'(DIM - 1);

  mm4_pkg::mm4_state_t state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] k_r, k_nxt;
  logic             start;
  logic             push;
  logic             last_elem;
  logic [CELL_W-1:0] pos;

  assign start     = (state_r == mm4_pkg::ST_LOAD) && in_valid && in_load_done;
  assign push      = (state_r == mm4_pkg::ST_FLUSH) && stat.dot_ready && stat.slot_free;
  assign last_elem = (row_r == LAST_RC) && (col_r == LAST_RC);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mm4_pkg::ST_LOAD: begin
        if (start) state_nxt = mm4_pkg::ST_MAC;
      end
      mm4_pkg::ST_MAC: begin
        if (k_r == LAST_RC) state_nxt = mm4_pkg::ST_FLUSH;
      end
      mm4_pkg::ST_FLUSH: begin
        if (push) state_nxt = last_elem ? mm4_pkg::ST_LOAD : mm4_pkg::ST_MAC;
      end
      default: state_nxt = mm4_pkg::ST_LOAD;
    endcase
  end

  // Row, column and inner-index counters
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    k_nxt   = k_r;
    if (start) begin
      row_nxt = '0;
      col_nxt = '0;
      k_nxt   = '0;
    end
    if (state_r == mm4_pkg::ST_MAC) begin
      k_nxt = (k_r == LAST_RC) ? '0 : k_r + 1'b1;
    end
    // column-major walk: row fastest
    if (push) begin
      if (row_r == LAST_RC) begin
        row_nxt = '0;
        col_nxt = col_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm4_pkg::ST_LOAD;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      k_r     <= k_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_ready       = (state_r == mm4_pkg::ST_LOAD);
    cmd.load       = (state_r == mm4_pkg::ST_LOAD) && in_valid;
    cmd.issue      = (state_r == mm4_pkg::ST_MAC);
    cmd.first      = (k_r == '0);
    cmd.last       = (k_r == LAST_RC);
    cmd.push       = push;
    cmd.final_elem = last_elem;
  end

  // A is read along a row, B down a column
  assign a_addr  = CELL_W'(row_r) + CELL_W'(k_r) * CELL_W'(DIM);
  assign b_addr  = CELL_W'(k_r) + CELL_W'(col_r) * CELL_W'(DIM);
  assign pos     = CELL_W'(row_r) + CELL_W'(col_r) * CELL_W'(DIM);
  assign out_pos = mm4_pkg::IDX_W'(pos);

endmodule

[design/mm4_dp.sv]
// Datapath: operand stores, shared multiplier, accumulator, saturation, output register.
`timescale 1ns / 1ps

module mm4_dp #(
  parameter int DIM = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mm4_pkg::mm4_cmd_t                 cmd,
  output mm4_pkg::mm4_stat_t                stat,
  input  logic [$clog2(DIM*DIM)-1:0]        a_addr,
  input  logic [$clog2(DIM*DIM)-1:0]        b_addr,
  input  logic [mm4_pkg::IDX_W-1:0]         out_pos,
  input  logic [mm4_pkg::IDX_W-1:0]         in_elem_index,
  input  logic signed [mm4_pkg::VAL_W-1:0]  in_left_value,
  input  logic signed [mm4_pkg::VAL_W-1:0]  in_right_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mm4_pkg::IDX_W-1:0]         out_index,
  output logic signed [mm4_pkg::VAL_W-1:0]  out_product_value,
  output logic                              out_final_element
);

  localparam int NCELLS = DIM * DIM;
  localparam int CELL_W = $clog2(NCELLS);
  localparam int ACC_W  = mm4_pkg::PROD_W + $clog2(DIM);
  localparam int VAL_W  = mm4_pkg::VAL_W;
  localparam int FRAC_W = mm4_pkg::FRAC_W;
  // bits from the top of the kept window upward must all match the sign
  localparam int TOP_LO = VAL_W + FRAC_W - 1;

  logic                     wr_en;
  logic [CELL_W-1:0]        wr_addr;
  logic [VAL_W-1:0]         a_dout, b_dout;
  logic                     rd_v_r, rd_first_r, rd_last_r;
  logic                     p_v_r, p_first_r, p_last_r;
  logic signed [mm4_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     dot_ready_r;
  logic                     sat_pos, sat_neg;
  logic [VAL_W-1:0]         sat_val;
  logic                     out_valid_r;
  logic [mm4_pkg::IDX_W-1:0] out_index_r;
  logic [VAL_W-1:0]         out_val_r;
  logic                     out_final_r;

  // Store writes; positions past the matrix are dropped
  assign wr_en   = cmd.load && (32'(in_elem_index) < 32'(NCELLS));
  assign wr_addr = CELL_W'(in_elem_index);

  mm4_ram #(.WIDTH(VAL_W), .DEPTH(NCELLS)) u_left_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_left_value),
    .re    (cmd.issue),
    .raddr (a_addr),
    .rdata (a_dout)
  );

  mm4_ram #(.WIDTH(VAL_W), .DEPTH(NCELLS)) u_right_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_right_value),
    .re    (cmd.issue),
    .raddr (b_addr),
    .rdata (b_dout)
  );

  // Pipeline control tags: read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      p_v_r       <= 1'b0;
      dot_ready_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.issue;
      p_v_r  <= rd_v_r;
      if (cmd.issue && cmd.first) begin
        dot_ready_r <= 1'b0;
      end else if (p_v_r && p_last_r) begin
        dot_ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= cmd.first;
    rd_last_r  <= cmd.last;
    p_first_r  <= rd_first_r;
    p_last_r   <= rd_last_r;
  end

  // Shared 32x32 signed multiplier, registered
  assign prod_nxt = $signed(a_dout) * $signed(b_dout);

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= prod_nxt;
    end
  end

  // Accumulator
  assign acc_nxt = p_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (p_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Shift right by FRAC_W and saturate to 32 bits
  always_comb begin
    sat_pos = !acc_r[ACC_W-1] && (|acc_r[ACC_W-1:TOP_LO]);
    sat_neg = acc_r[ACC_W-1] && !(&acc_r[ACC_W-1:TOP_LO]);
    if (sat_pos) begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sat_neg) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = acc_r[TOP_LO:FRAC_W];
    end
  end

  // Output register
  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.dot_ready = dot_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_index_r <= out_pos;
      out_val_r   <= sat_val;
      out_final_r <= cmd.final_elem;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_index         = out_index_r;
  assign out_product_value = out_val_r;
  assign out_final_element = out_final_r;

endmodule

[design/matrix_multiply_4x4.sv]
// Top level of the DIM x DIM signed Q16.16 column-major matrix multiplier.
`timescale 1ns / 1ps

// Load one beat per cycle; each beat writes A and B at the same column-major
// position (row + DIM*column). A beat with load_done set stores its elements
// and starts C = A*B over the current store contents, so all DIM*DIM positions
// must have been written before it. Each C element is the exact sum of DIM
// products, shifted right by 16 (toward minus infinity) and saturated to 32
// bits; the DIM*DIM results leave in column-major order, the last one flagged.
// One shared 32x32 multiplier computes the products: an element takes DIM
// operand reads, the multiply and accumulate registers and the push into the
// output register, and the next element's reads wait for that push, so
// output stalls hold up the multiply. Input is refused during the multiply
// and accepted again while the final result still waits in the output
// register.

module matrix_multiply_4x4 #(
  parameter int DIM = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mm4_pkg::IDX_W-1:0]         in_elem_index,
  input  logic signed [mm4_pkg::VAL_W-1:0]  in_left_value,
  input  logic signed [mm4_pkg::VAL_W-1:0]  in_right_value,
  input  logic                              in_load_done,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mm4_pkg::IDX_W-1:0]         out_index,
  output logic signed [mm4_pkg::VAL_W-1:0]  out_product_value,
  output logic                              out_final_element
);

  localparam int CELL_W = $clog2(DIM * DIM);

  mm4_pkg::mm4_cmd_t          cmd;
  mm4_pkg::mm4_stat_t         stat;
  logic [CELL_W-1:0]          a_addr, b_addr;
  logic [mm4_pkg::IDX_W-1:0]  out_pos;

  mm4_ctrl #(.DIM(DIM)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_load_done (in_load_done),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd),
    .a_addr       (a_addr),
    .b_addr       (b_addr),
    .out_pos      (out_pos)
  );

  mm4_dp #(.DIM(DIM)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .a_addr            (a_addr),
    .b_addr            (b_addr),
    .out_pos           (out_pos),
    .in_elem_index     (in_elem_index),
    .in_left_value     (in_left_value),
    .in_right_value    (in_right_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_index         (out_index),
    .out_product_value (out_product_value),
    .out_final_element (out_final_element)
  );

  // Loading and operand reads never overlap
  assert property (@(posedge clk) disable iff (!rst_n) cmd.issue |-> !in_ready)
    else $error("operand read while input is open");

  // A push never overwrites a result that has not been taken
  assert property (@(posedge clk) disable iff (!rst_n) cmd.push |-> stat.slot_free)
    else $error("push into a full output register");

  // A start beat is followed at once by the first operand read
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_load_done) |=> (cmd.issue && cmd.first))
    else $error("multiply did not start after a load_done beat");

  // Input reopens right after the final element is pushed
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && cmd.final_elem) |=> in_ready)
    else $error("input not reopened after the final element");

endmodule

[sim/matrix_multiply_4x4_test.sv]
// Self-checking testbench for the 4x4 Q16.16 column-major matrix multiplier.
`timescale 1ns / 1ps

module matrix_multiply_4x4_test;

  localparam int IDX_W   = mm4_pkg::IDX_W;
  localparam int VAL_W   = mm4_pkg::VAL_W;
  localparam int FRAC_W  = mm4_pkg::FRAC_W;
  localparam int DIM     = 4;
  localparam int N_CELLS = DIM * DIM;
  localparam int N_BEATS = 250;
  localparam int CALM_TAIL = 40;
  localparam int LONG_HOLD = 300;
  localparam logic signed [67:0] Q16_MAX = 68'sh7FFFFFFF;
  localparam logic signed [67:0] Q16_MIN = -68'sh80000000;

  // One input beat as queued for the driver
  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] a_val;
    logic signed [VAL_W-1:0] b_val;
    logic                    done;
    bit                      drain;  // hold off until all products are back
  } load_beat_t;

  // One product element
  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last_elem;
  } product_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_elem_index = '0;
  logic signed [VAL_W-1:0] in_left_value = '0;
  logic signed [VAL_W-1:0] in_right_value = '0;
  logic in_load_done = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_index;
  logic signed [VAL_W-1:0] out_product_value;
  logic out_final_element;

  load_beat_t pend_q[$];
  product_t product_q[$];
  logic signed [VAL_W-1:0] a_mem [N_CELLS];
  logic signed [VAL_W-1:0] b_mem [N_CELLS];

  bit in_accepted = 1'b0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;
  int send_gap = 0;
  int rdy_hold = 0;
  int products_seen = 0;
  int err_cnt = 0;

  matrix_multiply_4x4 DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_elem_index    (in_elem_index),
    .in_left_value    (in_left_value),
    .in_right_value   (in_right_value),
    .in_load_done     (in_load_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_index        (out_index),
    .out_product_value(out_product_value),
    .out_final_element(out_final_element)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Corner values of Q16.16
  function automatic logic signed [VAL_W-1:0] corner_q16(input int sel);
    case (sel % 8)
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sh00000000;
      3: return 32'shFFFFFFFF;
      4: return 32'sh00000001;
      5: return 32'sh00010000;
      6: return 32'shFFFF0000;
      default: return 32'shAAAAAAAA;
    endcase
  endfunction

  // Random Q16.16 value: full range, corners, or smaller magnitudes within +/-128.0 or +/-2.0
  function automatic logic signed [VAL_W-1:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return corner_q16($urandom_range(0, 7));
      2: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      default: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
    endcase
  endfunction

  // C[r][c] from the current stores: exact sum, floor shift by 16, saturate
  function automatic logic signed [VAL_W-1:0] dot_q16(input int r, input int c);
    logic signed [67:0] acc;
    logic signed [67:0] scaled;
    longint prod;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      prod = longint'(a_mem[r + DIM * k]) * longint'(b_mem[k + DIM * c]);
      acc = acc + prod;
    end
    scaled = acc >>> FRAC_W;
    if (scaled > Q16_MAX) return 32'sh7FFFFFFF;
    if (scaled < Q16_MIN) return 32'sh80000000;
    return scaled[VAL_W-1:0];
  endfunction

  task automatic add_beat(input int idx, input logic signed [VAL_W-1:0] a,
                          input logic signed [VAL_W-1:0] b, input logic done,
                          input bit drain);
    load_beat_t bt;
    bt.index = idx[IDX_W-1:0];
    bt.a_val = a;
    bt.b_val = b;
    bt.done  = done;
    bt.drain = drain;
    pend_q.push_back(bt);
  endtask

  task automatic log_error(input string msg);
    err_cnt++;
    $display("%0t: %s", $time, msg);
  endtask

  // Input driver: changes at the falling edge, one beat in flight at a time
  always @(negedge clk) begin : drive_input
    load_beat_t bt;
    logic go;
    go = in_valid;
    if (!rst_n) begin
      go = 1'b0;
    end else if (!(in_valid && !in_accepted)) begin
      go = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pend_q.size() != 0) begin
        if (pend_q[0].drain && product_q.size() != 0) begin
          // pause until the previous matrix is fully read out
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 6);
        end else begin
          bt = pend_q.pop_front();
          in_elem_index  <= bt.index;
          in_left_value  <= bt.a_val;
          in_right_value <= bt.b_val;
          in_load_done   <= bt.done;
          go = 1'b1;
        end
      end
    end
    in_valid <= go;
  end

  // Output ready: random stall bursts, one long hold to back up the block
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rdy_hold != 0) begin
      rdy_hold--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && products_seen >= 40) begin
      long_hold_done = 1'b1;
      rdy_hold = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rdy_hold = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Rising-edge monitor: check output beats, then predict from input beats
  always @(posedge clk) begin : monitor
    product_t want;
    if (!rst_n) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        products_seen++;
        if (product_q.size() == 0) begin
          log_error($sformatf("unexpected product: expected none, actual idx %0d val %h last %b",
                              out_index, out_product_value, out_final_element));
        end else begin
          want = product_q.pop_front();
          if (out_index !== want.index || out_product_value !== want.value ||
              out_final_element !== want.last_elem)
            log_error($sformatf({"product mismatch: expected idx %0d val %h last %b, ",
                                 "actual idx %0d val %h last %b"},
                                want.index, want.value, want.last_elem,
                                out_index, out_product_value, out_final_element));
        end
      end
      if (in_valid && in_ready) begin
        a_mem[in_elem_index] = in_left_value;
        b_mem[in_elem_index] = in_right_value;
        if (in_load_done) begin
          for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
              want.index     = IDX_W'(r + DIM * c);
              want.value     = dot_q16(r, c);
              want.last_elem = (r + DIM * c == N_CELLS - 1);
              product_q.push_back(want);
            end
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int len;
    int mode;
    bit first_seq;
    // Full load: A = identity, B = corner values, so C passes B through
    for (int i = 0; i < N_CELLS; i++)
      add_beat(i, (i % (DIM + 1) == 0) ? 32'sh00010000 : 32'sh0, corner_q16(i),
               i == N_CELLS - 1, 1'b0);
    // Saturation high and low, floor rounding of a small negative, repeat
    add_beat(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 1'b0);
    add_beat(5, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, 1'b0);
    add_beat(10, 32'shFFFFFFFF, 32'sh00000001, 1'b1, 1'b0);
    add_beat(15, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0);
    add_beat(15, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0);
    // Random sequences: partial rewrites ending in a multiply, full reloads, noise
    first_seq = 1'b1;
    while (pend_q.size() < N_BEATS) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(0, 15);
      if (mode == 0) begin
        for (int i = 0; i < N_CELLS; i++)
          add_beat(i, rand_q16(), rand_q16(), i == N_CELLS - 1, first_seq && i == 0);
      end else if (mode == 1) begin
        for (int i = 0; i <= len; i++)
          add_beat($urandom_range(0, 15), rand_q16(), rand_q16(), 1'b0,
                   first_seq && i == 0);
      end else begin
        for (int i = 0; i <= len; i++)
          add_beat($urandom_range(0, 15), rand_q16(), rand_q16(), i == len,
                   (first_seq || $urandom_range(0, 7) == 0) && i == 0);
      end
      first_seq = 1'b0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() > CALM_TAIL) @(posedge clk);
    calm = 1'b1;
    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (product_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_cnt == 0)
      $display("matrix_multiply_4x4_test: PASS");
    else
      $display("matrix_multiply_4x4_test: FAIL");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5000000;
    $display("matrix_multiply_4x4_test: FAIL");
    $finish;
  end

endmodule
